### hw/rtl/http_response_stream_parser_top_macros.svh
// Assertion macros used by the checker file hrsp_checker.sv.
`ifndef HTTP_RESPONSE_STREAM_PARSER_TOP_MACROS_SVH
`define HTTP_RESPONSE_STREAM_PARSER_TOP_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define HRSP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hrsp check failed");

// next-cycle implication
`define HRSP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hrsp check failed");

`endif

### hw/rtl/hrsp_pkg.sv
`default_nettype none

package hrsp_pkg;

   localparam int LENGTH_BITS_DEFAULT = 32;
   localparam int KEY_LEN = 14;

   localparam logic [2:0] PH_VERSION = 3'd0;
   localparam logic [2:0] PH_STATUS  = 3'd1;
   localparam logic [2:0] PH_REASON  = 3'd2;
   localparam logic [2:0] PH_KEY     = 3'd3;
   localparam logic [2:0] PH_VALUE   = 3'd4;
   localparam logic [2:0] PH_BODY    = 3'd5;
   localparam logic [2:0] PH_DONE    = 3'd6;

   localparam logic [2:0] CLS_VERSION   = 3'd0;
   localparam logic [2:0] CLS_STATUS    = 3'd1;
   localparam logic [2:0] CLS_REASON    = 3'd2;
   localparam logic [2:0] CLS_KEY       = 3'd3;
   localparam logic [2:0] CLS_VALUE     = 3'd4;
   localparam logic [2:0] CLS_BODY      = 3'd5;
   localparam logic [2:0] CLS_SEPARATOR = 3'd6;
   localparam logic [2:0] CLS_IGNORED   = 3'd7;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_STATUS = 2'd1;
   localparam logic [1:0] ERR_LENGTH = 2'd2;

   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [9:0] STATUS_MAX = 10'd999;

   typedef struct packed {
      logic [2:0]  byte_class;
      logic [7:0]  byte_value;
      logic [9:0]  status_code;
      logic [31:0] content_length;
      logic        headers_done;
      logic        response_done;
      logic [1:0]  parse_error;
   } result_type;

   // "Content-Length", one character per position
   function automatic logic [7:0] key_char(input logic [3:0] pos);
      logic [7:0] c;
      unique case (pos)
         4'd0:    c = 8'h43;
         4'd1:    c = 8'h6f;
         4'd2:    c = 8'h6e;
         4'd3:    c = 8'h74;
         4'd4:    c = 8'h65;
         4'd5:    c = 8'h6e;
         4'd6:    c = 8'h74;
         4'd7:    c = 8'h2d;
         4'd8:    c = 8'h4c;
         4'd9:    c = 8'h65;
         4'd10:   c = 8'h6e;
         4'd11:   c = 8'h67;
         4'd12:   c = 8'h74;
         4'd13:   c = 8'h68;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/hrsp_parse_core.sv
`default_nettype none

module hrsp_parse_core #(
   parameter int LENGTH_BITS = hrsp_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 first_byte,
   output hrsp_pkg::result_type      result
);
   import hrsp_pkg::*;

   localparam int PW = LENGTH_BITS + 4;

   logic [2:0]             phase_ff, phase_in, cur_phase;
   logic [9:0]             status_ff, status_in, cur_status;
   logic [1:0]             digits_ff, digits_in, cur_digits;
   logic [3:0]             pos_ff, pos_in, cur_pos;
   logic                   mis_ff, mis_in, cur_mis;
   logic [LENGTH_BITS-1:0] val_ff, val_in, cur_val;
   logic                   any_ff, any_in, cur_any;
   logic                   seen_ff, seen_in, cur_seen;
   logic [LENGTH_BITS-1:0] len_ff, len_in, cur_len;
   logic [LENGTH_BITS-1:0] body_ff, body_in, cur_body;
   logic [1:0]             err_ff, err_in, cur_err;

   logic                   is_digit;
   logic [3:0]             digit;
   logic [9:0]             status_prod;
   logic [PW-1:0]          val_prod;
   logic                   val_ovf;
   logic                   key_hit;
   logic                   raise_status;
   logic                   raise_length;
   logic [2:0]             cls;
   logic                   hdone;

   // first_byte restarts from the reset state
   always_comb begin
      cur_phase  = first_byte ? PH_VERSION : phase_ff;
      cur_status = first_byte ? '0 : status_ff;
      cur_digits = first_byte ? '0 : digits_ff;
      cur_pos    = first_byte ? '0 : pos_ff;
      cur_mis    = first_byte ? 1'b0 : mis_ff;
      cur_val    = first_byte ? '0 : val_ff;
      cur_any    = first_byte ? 1'b0 : any_ff;
      cur_seen   = first_byte ? 1'b0 : seen_ff;
      cur_len    = first_byte ? '0 : len_ff;
      cur_body   = first_byte ? '0 : body_ff;
      cur_err    = first_byte ? ERR_NONE : err_ff;
   end

   assign is_digit    = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
   assign digit       = data_byte[3:0];
   assign status_prod = (cur_status << 3) + (cur_status << 1) + 10'(digit);
   assign val_prod    = ({4'b0, cur_val} << 3) + ({4'b0, cur_val} << 1) + PW'(digit);
   assign val_ovf     = |val_prod[PW-1:LENGTH_BITS];
   assign key_hit     = (cur_pos < 4'(KEY_LEN)) && (data_byte == key_char(cur_pos));

   always_comb begin
      phase_in     = cur_phase;
      status_in    = cur_status;
      digits_in    = cur_digits;
      pos_in       = cur_pos;
      mis_in       = cur_mis;
      val_in       = cur_val;
      any_in       = cur_any;
      seen_in      = cur_seen;
      len_in       = cur_len;
      body_in      = cur_body;
      raise_status = 1'b0;
      raise_length = 1'b0;
      cls          = CLS_SEPARATOR;
      hdone        = 1'b0;
      unique case (cur_phase)
         PH_VERSION: begin
            if (data_byte == CH_SPACE) begin
               phase_in = PH_STATUS;
            end else begin
               cls = CLS_VERSION;
            end
         end
         PH_STATUS: begin
            if (data_byte == CH_SPACE) begin
               raise_status = (cur_digits == 2'd0);
               phase_in     = PH_REASON;
            end else begin
               cls = CLS_STATUS;
               if (!is_digit || cur_digits == 2'd3) begin
                  raise_status = 1'b1;
               end else begin
                  status_in = status_prod;
                  digits_in = cur_digits + 2'd1;
               end
            end
         end
         PH_REASON: begin
            if (data_byte == CH_LF) begin
               phase_in = PH_KEY;
               pos_in   = '0;
               mis_in   = 1'b0;
            end else if (data_byte != CH_CR) begin
               cls = CLS_REASON;
            end
         end
         PH_KEY: begin
            if (data_byte == CH_LF) begin
               hdone = 1'b1;
               if (cur_seen && cur_len != '0) begin
                  body_in  = cur_len;
                  phase_in = PH_BODY;
               end else begin
                  phase_in = PH_DONE;
               end
            end else if (data_byte == CH_SPACE) begin
               // mis now marks a value that is not latched
               mis_in   = !(!cur_mis && cur_pos == 4'(KEY_LEN) && !cur_seen);
               val_in   = '0;
               any_in   = 1'b0;
               phase_in = PH_VALUE;
            end else if (data_byte != CH_CR && data_byte != CH_COLON) begin
               cls = CLS_KEY;
               if (key_hit) begin
                  pos_in = cur_pos + 4'd1;
               end else begin
                  mis_in = 1'b1;
               end
            end
         end
         PH_VALUE: begin
            if (data_byte == CH_LF) begin
               if (!cur_mis) begin
                  raise_length = !cur_any;
                  seen_in      = 1'b1;
                  len_in       = cur_val;
               end
               phase_in = PH_KEY;
               pos_in   = '0;
               mis_in   = 1'b0;
            end else if (data_byte != CH_CR) begin
               cls = CLS_VALUE;
               if (!cur_mis) begin
                  if (!is_digit) begin
                     raise_length = 1'b1;
                  end else begin
                     any_in = 1'b1;
                     if (val_ovf) begin
                        raise_length = 1'b1;
                        val_in       = '1;
                     end else begin
                        val_in = val_prod[LENGTH_BITS-1:0];
                     end
                  end
               end
            end
         end
         PH_BODY: begin
            cls     = CLS_BODY;
            body_in = cur_body - LENGTH_BITS'(1);
            if (body_in == '0) begin
               phase_in = PH_DONE;
            end
         end
         default: begin
            cls      = CLS_IGNORED;
            phase_in = PH_DONE;
         end
      endcase
   end

   always_comb begin
      priority if (cur_err != ERR_NONE) begin
         err_in = cur_err;
      end else if (raise_status) begin
         err_in = ERR_STATUS;
      end else if (raise_length) begin
         err_in = ERR_LENGTH;
      end else begin
         err_in = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_VERSION;
         status_ff <= '0;
         digits_ff <= '0;
         pos_ff    <= '0;
         mis_ff    <= 1'b0;
         val_ff    <= '0;
         any_ff    <= 1'b0;
         seen_ff   <= 1'b0;
         len_ff    <= '0;
         body_ff   <= '0;
         err_ff    <= ERR_NONE;
      end else if (step) begin
         phase_ff  <= phase_in;
         status_ff <= status_in;
         digits_ff <= digits_in;
         pos_ff    <= pos_in;
         mis_ff    <= mis_in;
         val_ff    <= val_in;
         any_ff    <= any_in;
         seen_ff   <= seen_in;
         len_ff    <= len_in;
         body_ff   <= body_in;
         err_ff    <= err_in;
      end
   end

   always_comb begin
      result.byte_class     = cls;
      result.byte_value     = data_byte;
      result.status_code    = status_in;
      result.content_length = 32'(len_in);
      result.headers_done   = hdone;
      result.response_done  = (phase_in == PH_DONE);
      result.parse_error    = err_in;
   end

endmodule

`default_nettype wire

### hw/rtl/http_response_stream_parser_top.sv
// channel  | direction | handshake              | payload
// req      | in        | req_valid / req_ready  | data_byte, first_byte
// rsp      | out       | rsp_valid / rsp_ready  | byte_class .. parse_error
//
// One byte per cycle sustained while rsp is not stalled; a req byte reaches rsp through
// the input register, then the parse logic into the output register.
// Parser state updates as a byte moves from the input to the output register.
// Synchronous active-high reset clears both stages and all parser state.
// A stalled rsp holds; req stays open while the input register can drain.
`default_nettype none

module http_response_stream_parser_top #(
   parameter int LENGTH_BITS = hrsp_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_first_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_byte_class,
   output logic [7:0]       rsp_byte_value,
   output logic [9:0]       rsp_status_code,
   output logic [31:0]      rsp_content_length,
   output logic             rsp_headers_done,
   output logic             rsp_response_done,
   output logic [1:0]       rsp_parse_error
);
   import hrsp_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type core_result;
   logic       out_free;
   logic       advance;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   hrsp_parse_core #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .data_byte  (in_byte_ff),
      .first_byte (in_first_ff),
      .result     (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= advance;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_data_byte;
         in_first_ff <= req_first_byte;
      end
      if (advance) begin
         out_ff <= core_result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_byte_class     = out_ff.byte_class;
   assign rsp_byte_value     = out_ff.byte_value;
   assign rsp_status_code    = out_ff.status_code;
   assign rsp_content_length = out_ff.content_length;
   assign rsp_headers_done   = out_ff.headers_done;
   assign rsp_response_done  = out_ff.response_done;
   assign rsp_parse_error    = out_ff.parse_error;

endmodule

`default_nettype wire

### hw/rtl/hrsp_checker.sv
`default_nettype none

`include "http_response_stream_parser_top_macros.svh"

module hrsp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_byte_class,
   input wire logic [7:0]  rsp_byte_value,
   input wire logic [9:0]  rsp_status_code,
   input wire logic        rsp_headers_done,
   input wire logic        rsp_response_done
);
   import hrsp_pkg::*;

   `HRSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_byte_value))
   `HRSP_ASSERT_NOW(a_hdone_sep, rsp_valid && rsp_headers_done, rsp_byte_class == CLS_SEPARATOR)
   `HRSP_ASSERT_NOW(a_ignored_done, rsp_valid && rsp_byte_class == CLS_IGNORED, rsp_response_done)
   `HRSP_ASSERT_NOW(a_status_range, rsp_valid, rsp_status_code <= STATUS_MAX)

endmodule

bind http_response_stream_parser_top hrsp_checker u_hrsp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_byte_class    (rsp_byte_class),
   .rsp_byte_value    (rsp_byte_value),
   .rsp_status_code   (rsp_status_code),
   .rsp_headers_done  (rsp_headers_done),
   .rsp_response_done (rsp_response_done)
);

`default_nettype wire
